// ===== sv/fea_pkg.sv =====
// Package for the flow EWMA anomaly gate: widths, reset values, opcodes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fea_pkg;
  localparam int unsigned TableEntriesDef = 16;
  localparam int unsigned DataW = 32;
  localparam logic [2:0] ShiftRst = 3'd3;
  localparam logic [7:0] DropRst = 8'd75;
  localparam logic [7:0] MarkRst = 8'd30;
  localparam logic [5:0] ScoreWeight = 6'd50;

  localparam logic OpRegister = 1'b0;
  localparam logic OpEvaluate = 1'b1;

  localparam logic [1:0] CfgShift = 2'd0;
  localparam logic [1:0] CfgDrop  = 2'd1;
  localparam logic [1:0] CfgMark  = 2'd2;

  localparam logic [1:0] DecPass = 2'd0;
  localparam logic [1:0] DecMark = 2'd1;
  localparam logic [1:0] DecDrop = 2'd2;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage
`default_nettype wire

// ===== sv/fea_ram.sv =====
// Generic RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fea_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                           rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/fea_div.sv =====
// Bit-serial restoring divider: 38-bit dividend by 32-bit divisor, one
// quotient bit per cycle. Depends on fea_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fea_div
  import fea_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [37:0]      dividend_i,
  input  wire logic [DataW-1:0] divisor_i,
  output div_ctl_t              ctl_o,
  output logic      [37:0]      quot_o
);
  logic [37:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [DataW-1:0] dvs_q, dvs_d;
  logic [5:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [33:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q, quo_q[37]} - {2'b00, dvs_q};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
      cnt_d = 6'd38;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract when it fits
      if (!trial[33]) begin
        rem_d = trial[32:0];
        quo_d = {quo_q[36:0], 1'b1};
      end else begin
        rem_d = {rem_q[31:0], quo_q[37]};
        quo_d = {quo_q[36:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy = busy_q;
  assign quot_o = quo_q;

`ifndef SYNTH
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 6'd0) else $error("divider busy with zero count");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("divider did not start");
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == 6'd0) else $error("divider idle with count left");
`endif
endmodule
`default_nettype wire

// ===== sv/flow_ewma_anomaly_gate_unit.sv =====
// Top level of the flow EWMA anomaly gate: source table, lookup, averaging,
// scoring. Depends on fea_pkg, fea_ram and fea_div.
//
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid_i/stall | opcode, source id, time, bytes, expectations
// out     | output    | out_valid_o/stall| decision, score, unknown, refused
// cfg     | input     | cfg_we_i         | cfg_index_i, cfg_data_i
//
// One item at a time. An evaluate item scans the table with one RAM read per
// entry scanned, then runs up to two serial 38-bit divisions. The result sits
// in an output register; the input is taken again once it is delivered.
// Reset clears the entry count, so the table is empty without a sweep.
`timescale 1ns / 1ps
`default_nettype none
module flow_ewma_anomaly_gate_unit
  import fea_pkg::*;
#(
  parameter int unsigned TableEntries = TableEntriesDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             in_opcode_i,
  input  wire logic [DataW-1:0] in_source_id_i,
  input  wire logic [DataW-1:0] in_arrival_time_ms_i,
  input  wire logic [DataW-1:0] in_packet_bytes_i,
  input  wire logic [DataW-1:0] in_expected_interval_ms_i,
  input  wire logic [DataW-1:0] in_expected_volume_bytes_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [1:0]       out_decision_o,
  output logic      [7:0]       out_anomaly_score_o,
  output logic                  out_unknown_source_o,
  output logic                  out_registration_refused_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [7:0]       cfg_data_i
);
  localparam int unsigned AddrW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam int unsigned RowW = 6 * DataW;
  localparam logic [CntW-1:0] FullCnt = CntW'(TableEntries);

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StRead  = 9'b000000010,
    StCmp   = 9'b000000100,
    StUpd   = 9'b000001000,
    StDivI  = 9'b000010000,
    StWaitI = 9'b000100000,
    StDivV  = 9'b001000000,
    StWaitV = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e st_q, st_d;
  logic [2:0] shift_q;
  logic [7:0] drop_q, mark_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;

  logic [DataW-1:0] id_q, now_q, bytes_q, ei_q, ev_q;
  logic op_q;
  logic [DataW-1:0] ia_q, va_q, eit_q, evt_q;
  logic [8:0] score_q, score_d;
  logic out_valid_q;
  logic [1:0] dec_q;
  logic unk_q, ref_q;

  logic ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [RowW-1:0] ram_wdata, ram_rdata;
  logic [DataW-1:0] r_id, r_ei, r_ev, r_lt, r_ia, r_va;

  logic div_start;
  logic [37:0] div_dvd, div_quot;
  logic [DataW-1:0] div_dvs;
  div_ctl_t div_ctl;

  logic [DataW-1:0] sample, dif_i, dif_v, stp_i, stp_v, nia, nva;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle) || out_valid_q;

  // row layout: id, expected interval, expected volume, last, iavg, vavg
  assign {r_id, r_ei, r_ev, r_lt, r_ia, r_va} = ram_rdata;

  fea_ram #(.Width(RowW), .Depth(TableEntries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fea_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .ctl_o      (div_ctl),
    .quot_o     (div_quot)
  );

  assign ram_raddr = idx_q[AddrW-1:0];

  // EWMA step: arithmetic shift of the wrapped difference
  assign sample = (r_lt == '0) ? r_ei : (now_q - r_lt);
  assign dif_i = sample - r_ia;
  assign dif_v = bytes_q - r_va;
  assign stp_i = DataW'($signed(dif_i) >>> shift_q);
  assign stp_v = DataW'($signed(dif_v) >>> shift_q);
  assign nia = r_ia + stp_i;
  assign nva = r_va + stp_v;

  function automatic logic ref_d_cond();
    ref_d_cond = (count_q >= FullCnt) || (ei_q == '0) || (ev_q == '0);
  endfunction

  always_comb begin
    st_d = st_q;
    count_d = count_q;
    idx_d = idx_q;
    score_d = score_q;
    ram_we = 1'b0;
    ram_waddr = idx_q[AddrW-1:0];
    ram_wdata = {id_q, ei_q, ev_q, {DataW{1'b0}}, ei_q, ev_q};
    div_start = 1'b0;
    div_dvd = {6'd0, eit_q - ia_q} * 38'(ScoreWeight);
    div_dvs = eit_q;
    case (st_q)
      StIdle: begin
        if (in_acc) begin
          idx_d = '0;
          score_d = '0;
          st_d = (in_opcode_i == OpEvaluate) ? StRead : StOut;
        end
      end
      StRead: begin
        if (idx_q >= count_q) begin
          st_d = StOut;
        end else begin
          st_d = StCmp;
        end
      end
      StCmp: begin
        if (r_id == id_q) begin
          st_d = StUpd;
        end else begin
          idx_d = idx_q + CntW'(1);
          st_d = StRead;
        end
      end
      StUpd: begin
        ram_we = 1'b1;
        ram_wdata = {r_id, r_ei, r_ev, now_q, nia, nva};
        st_d = StDivI;
      end
      StDivI: begin
        if (ia_q < eit_q) begin
          div_start = 1'b1;
          st_d = StWaitI;
        end else begin
          st_d = StDivV;
        end
      end
      StWaitI: begin
        if (!div_ctl.busy && !div_ctl.start) begin
          score_d = (div_quot > 38'd255) ? 9'd255 : {1'b0, div_quot[7:0]};
          st_d = StDivV;
        end
      end
      StDivV: begin
        div_dvd = {6'd0, va_q - evt_q} * 38'(ScoreWeight);
        div_dvs = evt_q;
        if (va_q > evt_q) begin
          div_start = 1'b1;
          st_d = StWaitV;
        end else begin
          st_d = StOut;
        end
      end
      StWaitV: begin
        div_dvs = evt_q;
        if (!div_ctl.busy && !div_ctl.start) begin
          score_d = (div_quot > 38'd255) ? 9'd255 :
                    ((score_q + {1'b0, div_quot[7:0]} > 9'd255) ? 9'd255 :
                     score_q + {1'b0, div_quot[7:0]});
          st_d = StOut;
        end
      end
      StOut: begin
        if (!op_q && !ref_d_cond()) begin
          ram_we = 1'b1;
          ram_waddr = count_q[AddrW-1:0];
          count_d = count_q + CntW'(1);
        end
        st_d = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      count_q <= '0;
      idx_q <= '0;
      shift_q <= ShiftRst;
      drop_q <= DropRst;
      mark_q <= MarkRst;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      count_q <= count_d;
      idx_q <= idx_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgShift: shift_q <= cfg_data_i[2:0];
          CfgDrop:  drop_q <= cfg_data_i;
          CfgMark:  mark_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (st_q == StOut) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    if (in_acc) begin
      op_q <= in_opcode_i;
      id_q <= in_source_id_i;
      now_q <= in_arrival_time_ms_i;
      bytes_q <= in_packet_bytes_i;
      ei_q <= in_expected_interval_ms_i;
      ev_q <= in_expected_volume_bytes_i;
    end
    if (st_q == StUpd) begin
      ia_q <= nia;
      va_q <= nva;
      eit_q <= r_ei;
      evt_q <= r_ev;
    end
    if (st_q == StOut) begin
      ref_q <= !op_q && ref_d_cond();
      unk_q <= op_q && (idx_q >= count_q);
      if (!op_q) begin
        dec_q <= DecPass;
      end else if (idx_q >= count_q) begin
        dec_q <= DecDrop;
      end else if (score_q[7:0] > drop_q) begin
        dec_q <= DecDrop;
      end else if (score_q[7:0] > mark_q) begin
        dec_q <= DecMark;
      end else begin
        dec_q <= DecPass;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_decision_o = dec_q;
  assign out_anomaly_score_o = (op_q && idx_q < count_q) ? score_q[7:0] : 8'd0;
  assign out_unknown_source_o = unk_q;
  assign out_registration_refused_o = ref_q;

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt) else $error("entry count past table size");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> in_stall_o) else $error("input taken while busy");
  a_out_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut) |=> out_valid_q) else $error("result not presented");
  a_lt_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StUpd) |=> $stable(count_q)) else $error("count moved on update");
`endif
endmodule
`default_nettype wire

// ===== tb/tb_flow_ewma_anomaly_gate_unit.sv =====
// Testbench for flow_ewma_anomaly_gate_unit: drives register/evaluate beats,
// predicts table, averages and score, and checks every result. Depends on fea_pkg and flow_ewma_anomaly_gate_unit.
`timescale 1ns / 1ps
module tb_flow_ewma_anomaly_gate_unit;
  import fea_pkg::*;

  typedef struct packed {
    logic        opcode;
    logic [31:0] source_id;
    logic [31:0] arrival;
    logic [31:0] bytes_n;
    logic [31:0] exp_iv;
    logic [31:0] exp_vol;
  } flow_item_t;

  typedef struct packed {
    logic [1:0] decision;
    logic [7:0] score;
    logic       unknown;
    logic       refused;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic in_opcode_i = 1'b0;
  logic [31:0] in_source_id_i = '0, in_arrival_time_ms_i = '0, in_packet_bytes_i = '0;
  logic [31:0] in_expected_interval_ms_i = '0, in_expected_volume_bytes_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [1:0] out_decision_o;
  logic [7:0] out_anomaly_score_o;
  logic out_unknown_source_o, out_registration_refused_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  flow_ewma_anomaly_gate_unit uut (.*);

  // predictor state
  logic [2:0]  avg_shift;
  logic [7:0]  drop_thr, mark_thr;
  int unsigned n_entries;
  logic [31:0] t_id[16], t_ei[16], t_ev[16], t_last[16], t_ia[16], t_va[16];

  flow_item_t pending_beats[$];
  verdict_t   expected_verdicts[$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  logic [31:0] known_ids[$];
  logic [31:0] clock_ms;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [31:0] ewma_step(logic [31:0] avg, logic [31:0] sample);
    logic signed [31:0] diff;
    diff = sample - avg;
    return avg + 32'(diff >>> avg_shift);
  endfunction

  function automatic logic [63:0] weighted_part(logic [31:0] d, logic [31:0] e);
    if (e == 0) return 64'd0;
    return ({32'd0, d} * 64'd50) / {32'd0, e};
  endfunction

  function automatic verdict_t gate_predict(flow_item_t it);
    verdict_t v;
    int hit;
    logic [31:0] sample, ia, va;
    logic [63:0] sc;
    v = '0;
    hit = -1;
    sc = 0;
    if (it.opcode == OpRegister) begin
      if (n_entries >= 16 || it.exp_iv == 0 || it.exp_vol == 0) begin
        v.refused = 1'b1;
      end else begin
        t_id[n_entries] = it.source_id; t_ei[n_entries] = it.exp_iv;
        t_ev[n_entries] = it.exp_vol; t_last[n_entries] = 0;
        t_ia[n_entries] = it.exp_iv; t_va[n_entries] = it.exp_vol;
        n_entries++;
      end
      return v;
    end
    for (int i = 0; i < n_entries; i++)
      if (hit < 0 && t_id[i] == it.source_id) hit = i;
    if (hit < 0) begin
      v.decision = DecDrop;
      v.unknown = 1'b1;
      return v;
    end
    sample = (t_last[hit] == 0) ? t_ei[hit] : it.arrival - t_last[hit];
    ia = ewma_step(t_ia[hit], sample);
    va = ewma_step(t_va[hit], it.bytes_n);
    t_ia[hit] = ia; t_va[hit] = va; t_last[hit] = it.arrival;
    if (ia < t_ei[hit]) sc += weighted_part(t_ei[hit] - ia, t_ei[hit]);
    if (va > t_ev[hit]) sc += weighted_part(va - t_ev[hit], t_ev[hit]);
    if (sc > 255) sc = 255;
    v.score = sc[7:0];
    if (v.score > drop_thr) v.decision = DecDrop;
    else if (v.score > mark_thr) v.decision = DecMark;
    else v.decision = DecPass;
    return v;
  endfunction

  // driver: advance on accept, hold payload while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (in_valid_i) expected_verdicts.push_back(gate_predict(pending_beats.pop_front()));
        if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_opcode_i <= pending_beats[0].opcode;
          in_source_id_i <= pending_beats[0].source_id;
          in_arrival_time_ms_i <= pending_beats[0].arrival;
          in_packet_bytes_i <= pending_beats[0].bytes_n;
          in_expected_interval_ms_i <= pending_beats[0].exp_iv;
          in_expected_volume_bytes_i <= pending_beats[0].exp_vol;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor and stall generation
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_verdicts.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (out_decision_o !== exp_v.decision) begin
            $error("decision exp %0d got %0d", exp_v.decision, out_decision_o); errors++;
          end
          if (out_anomaly_score_o !== exp_v.score) begin
            $error("anomaly_score exp %0d got %0d", exp_v.score, out_anomaly_score_o);
            errors++;
          end
          if (out_unknown_source_o !== exp_v.unknown) begin
            $error("unknown_source exp %0d got %0d", exp_v.unknown, out_unknown_source_o);
            errors++;
          end
          if (out_registration_refused_o !== exp_v.refused) begin
            $error("registration_refused exp %0d got %0d", exp_v.refused,
                   out_registration_refused_o);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgShift: avg_shift = val[2:0];
      CfgDrop:  drop_thr = val;
      CfgMark:  mark_thr = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_valid_i || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic flow_item_t mk(logic op, logic [31:0] id, logic [31:0] t,
                                    logic [31:0] b, logic [31:0] ei, logic [31:0] ev);
    flow_item_t it;
    it.opcode = op; it.source_id = id; it.arrival = t;
    it.bytes_n = b; it.exp_iv = ei; it.exp_vol = ev;
    return it;
  endfunction

  function automatic logic [31:0] rnd_wide();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(2000, 1);
      2: return 32'hFFFF_FFFF - $urandom_range(50);
      default: return $urandom_range(200000);
    endcase
  endfunction

  // random stream: mostly evaluates of known ids, with some registrations and unknown ids
  task automatic queue_random(int count);
    logic [31:0] id;
    int r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      if (r < 8 || known_ids.size() == 0) begin
        id = ($urandom_range(3) == 0) ? $urandom : $urandom_range(40);
        if (n_entries + 0 < 99) known_ids.push_back(id);
        pending_beats.push_back(mk(OpRegister, id, $urandom, $urandom,
          ($urandom_range(15) == 0) ? 32'd0 : rnd_wide(),
          ($urandom_range(15) == 0) ? 32'd0 : rnd_wide()));
      end else if (r < 14) begin
        pending_beats.push_back(mk(OpEvaluate, $urandom, $urandom, $urandom, $urandom,
                                   $urandom));
      end else begin
        id = known_ids[$urandom_range(known_ids.size() - 1)];
        clock_ms += $urandom_range(3) == 0 ? $urandom : $urandom_range(3000);
        pending_beats.push_back(mk(OpEvaluate, id,
          ($urandom_range(40) == 0) ? 32'd0 : clock_ms, rnd_wide(), $urandom, $urandom));
      end
    end
  endtask

  initial begin
    avg_shift = ShiftRst; drop_thr = DropRst; mark_thr = MarkRst;
    n_entries = 0;
    clock_ms = 32'd1000;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: refusals, extremes, unseen source, stamp zero, duplicates, unknown
    pending_beats.push_back(mk(OpEvaluate, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    pending_beats.push_back(mk(OpRegister, 32'h1, 0, 0, 32'd0, 32'd100));
    pending_beats.push_back(mk(OpRegister, 32'h1, 0, 0, 32'd100, 32'd0));
    pending_beats.push_back(mk(OpRegister, 32'hFFFF_FFFF, 0, 0, 32'd100, 32'd1000));
    pending_beats.push_back(mk(OpRegister, 32'h0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_beats.push_back(mk(OpRegister, 32'h0, 0, 0, 32'd1, 32'd1));
    pending_beats.push_back(mk(OpRegister, 32'h5, 0, 0, 32'd1, 32'd1));
    pending_beats.push_back(mk(OpEvaluate, 32'hFFFF_FFFF, 32'd0, 32'd1000, 0, 0));
    pending_beats.push_back(mk(OpEvaluate, 32'hFFFF_FFFF, 32'd50, 32'hFFFF_FFFF, 0, 0));
    pending_beats.push_back(mk(OpEvaluate, 32'hFFFF_FFFF, 32'd60, 32'd0, 0, 0));
    pending_beats.push_back(mk(OpEvaluate, 32'hFFFF_FFFF, 32'd10, 32'd5000, 0, 0));
    pending_beats.push_back(mk(OpEvaluate, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    pending_beats.push_back(mk(OpEvaluate, 32'h0, 32'd3, 32'd0, 0, 0));
    pending_beats.push_back(mk(OpEvaluate, 32'h5, 32'd7, 32'd900, 0, 0));
    pending_beats.push_back(mk(OpEvaluate, 32'h1234_5678, 32'd7, 32'd9, 0, 0));
    for (int k = 0; k < 6; k++)
      pending_beats.push_back(mk(OpRegister, 32'd100 + k, 0, 0, 32'd50, 32'd500));
    pending_beats.push_back(mk(OpRegister, 32'd999, 0, 0, 32'd50, 32'd500));
    known_ids.push_back(32'hFFFF_FFFF); known_ids.push_back(32'h0);
    drain();

    // phase 1: sender idles rarely, receiver often
    cfg_write(CfgShift, 8'd0); cfg_write(CfgDrop, 8'd255); cfg_write(CfgMark, 8'd0);
    send_idle_pct = 30; recv_idle_pct = 83;
    queue_random(500);
    drain();
    // phase 2: swap; no reset, so the table keeps its entries, keep going
    cfg_write(CfgShift, 8'd7); cfg_write(CfgDrop, 8'd0); cfg_write(CfgMark, 8'd255);
    send_idle_pct = 83; recv_idle_pct = 30;
    queue_random(500);
    drain();
    cfg_write(CfgShift, 8'd2); cfg_write(CfgDrop, 8'd60); cfg_write(CfgMark, 8'd20);
    send_idle_pct = 0; recv_idle_pct = 0;
    queue_random(530);
    drain();
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
